### src/sol_pkg.sv
// Package for the self-organising list lookup: types, codes and default sizes.
package sol_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int VALUE_W         = 32;

    localparam logic [1:0] MODE_SWAP_FRONT = 2'd0;
    localparam logic [1:0] MODE_TRANSPOSE  = 2'd1;
    localparam logic [1:0] MODE_COUNT      = 2'd2;
    localparam logic [1:0] MODE_RESERVED   = 2'd3;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] key;
        logic        [7:0]  slot;
        logic signed [31:0] load_value;
    } sol_item_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] position_before;
        logic [7:0] position_after;
    } sol_result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WR1,
        ST_WR2,
        ST_LOAD,
        ST_DONE
    } sol_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_item;
        logic clear_write;
        logic issue;
        logic compare;
        logic wr1;
        logic wr2;
        logic load_write;
        logic res_en;
        logic res_hit;
    } sol_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_load;
        logic clear_last;
        logic issued_all;
        logic match;
        logic last;
        logic w2_en;
    } sol_status_t;

endpackage

### src/self_organizing_list_lookup.sv
// Top level of the self-organising list lookup: controller and datapath joined.
//
// Usage. An item (a lookup or a load) is presented on item and is accepted at
// a rising edge at which start is high and busy is low. Exactly one result
// follows each item: it is on result while done is high, which is for a single cycle.
// The receiver cannot hold results off, so it must take the result in that cycle.
// The reorder rule is set through cfg_write and cfg_data, and should only be
// changed while busy is low.
//
// Operation. Entries are read one per cycle through the single memory read port and
// compared in the cycle after the read. A hit is followed by the reorder write state ST_WR1
// and, when a second write is needed, ST_WR2 before done; a miss reaches done after
// the last entry is compared, and a load after its single table write. busy falls
// the cycle after done.
//
// Reset. After rst_n is released the table is initialised by a clearing pass
// over every entry (entry i takes value i, its count zero), during which
// busy stays high; configuration writes are still taken during that pass.
module self_organizing_list_lookup #(
    parameter int TABLE_DEPTH = sol_pkg::TABLE_DEPTH_DEF,
    parameter int COUNT_WIDTH = sol_pkg::COUNT_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  sol_pkg::sol_item_t   item,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_data,
    output logic                 done,
    output sol_pkg::sol_result_t result
);

    sol_pkg::sol_cmd_t    cmd;
    sol_pkg::sol_status_t status;

    // The controller sequences clearing, scanning, loads, reorder writes and the result strobe.
    sol_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // The datapath holds the table memory, the reorder rule and the result register.
    sol_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

### src/sol_dp.sv
// Datapath of the self-organising list lookup: table memory, scan pipeline and reorder writes.
module sol_dp #(
    parameter int TABLE_DEPTH = sol_pkg::TABLE_DEPTH_DEF,
    parameter int COUNT_WIDTH = sol_pkg::COUNT_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sol_pkg::sol_item_t  item,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_data,
    input  sol_pkg::sol_cmd_t   cmd,
    output sol_pkg::sol_status_t status,
    output sol_pkg::sol_result_t result
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W = sol_pkg::VALUE_W + COUNT_WIDTH;

    logic [WORD_W-1:0] mem_array [TABLE_DEPTH];

    logic [1:0]             mode_reg, mode_next;
    logic [CNT_W-1:0]       addr_reg, addr_next;
    logic                   rvalid_reg, rvalid_next;
    logic [IDX_W-1:0]       ridx_reg;
    logic [WORD_W-1:0]      rdata_reg;
    sol_pkg::sol_item_t     item_reg;
    logic [31:0]            hit_val_reg, prev_val_reg, e0_val_reg;
    logic [COUNT_WIDTH-1:0] hit_cnt_reg, prev_cnt_reg, e0_cnt_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    sol_pkg::sol_result_t   result_reg;

    logic [31:0]            rd_val;
    logic [COUNT_WIDTH-1:0] rd_cnt;
    logic                   cmp_en;
    logic                   match;

    logic                   w1_en, w2_en;
    logic [IDX_W-1:0]       w1_addr, w2_addr, after_idx, pred_idx;
    logic [WORD_W-1:0]      w1_data, w2_data;
    logic [COUNT_WIDTH-1:0] new_cnt;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [WORD_W-1:0]      wr_data;
    logic [IDX_W+7:0]       slot_ext;
    logic [IDX_W+7:0]       before_ext, after_ext;
    logic                   slot_ok;

    assign rd_val = rdata_reg[WORD_W-1:COUNT_WIDTH];
    assign rd_cnt = rdata_reg[COUNT_WIDTH-1:0];
    assign cmp_en = cmd.compare && rvalid_reg;
    assign match  = cmp_en && (rd_val == item_reg.key);

    // Control registers.
    always_comb
    begin
        mode_next   = cfg_write ? cfg_data : mode_reg;
        addr_next   = addr_reg;
        if (cmd.latch_item)
        begin
            addr_next = '0;
        end
        else if (cmd.clear_write || cmd.issue)
        begin
            addr_next = addr_reg + 1'b1;
        end
        rvalid_next = cmd.issue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= sol_pkg::MODE_SWAP_FRONT;
            addr_reg   <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            addr_reg   <= addr_next;
            rvalid_reg <= rvalid_next;
        end
    end

    // Scan pipeline and captured entries.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_reg <= item;
        end
        if (cmd.issue)
        begin
            ridx_reg <= addr_reg[IDX_W-1:0];
        end
        if (cmp_en)
        begin
            if (ridx_reg == '0)
            begin
                e0_val_reg <= rd_val;
                e0_cnt_reg <= rd_cnt;
            end
            if (match)
            begin
                hit_val_reg <= rd_val;
                hit_cnt_reg <= rd_cnt;
                hit_idx_reg <= ridx_reg;
            end
            else
            begin
                prev_val_reg <= rd_val;
                prev_cnt_reg <= rd_cnt;
            end
        end
        if (cmd.res_en)
        begin
            result_reg <= result_next();
        end
    end

    function automatic sol_pkg::sol_result_t result_next();
        sol_pkg::sol_result_t r;
        r.hit             = cmd.res_hit;
        r.position_before = cmd.res_hit ? before_ext[7:0] : 8'd0;
        r.position_after  = cmd.res_hit ? after_ext[7:0] : 8'd0;
        return r;
    endfunction

    assign before_ext = {8'b0, hit_idx_reg};
    assign after_ext  = {8'b0, after_idx};

    // Reorder plan, worked out from the captured hit, predecessor and first entry.
    assign pred_idx = hit_idx_reg - 1'b1;
    assign new_cnt  = (hit_cnt_reg == '1) ? hit_cnt_reg : hit_cnt_reg + 1'b1;

    always_comb
    begin
        w1_en     = 1'b0;
        w2_en     = 1'b0;
        w1_addr   = hit_idx_reg;
        w2_addr   = hit_idx_reg;
        w1_data   = {hit_val_reg, hit_cnt_reg};
        w2_data   = {hit_val_reg, hit_cnt_reg};
        after_idx = hit_idx_reg;
        case (mode_reg)
            sol_pkg::MODE_SWAP_FRONT:
            begin
                if (hit_idx_reg != '0)
                begin
                    w1_en     = 1'b1;
                    w2_en     = 1'b1;
                    w1_addr   = '0;
                    w1_data   = {hit_val_reg, e0_cnt_reg};
                    w2_data   = {e0_val_reg, hit_cnt_reg};
                    after_idx = '0;
                end
            end
            sol_pkg::MODE_TRANSPOSE:
            begin
                if (hit_idx_reg != '0)
                begin
                    w1_en     = 1'b1;
                    w2_en     = 1'b1;
                    w1_addr   = pred_idx;
                    w1_data   = {hit_val_reg, prev_cnt_reg};
                    w2_data   = {prev_val_reg, hit_cnt_reg};
                    after_idx = pred_idx;
                end
            end
            sol_pkg::MODE_COUNT:
            begin
                w1_en = 1'b1;
                if ((hit_idx_reg != '0) && (new_cnt > prev_cnt_reg))
                begin
                    w2_en     = 1'b1;
                    w1_addr   = pred_idx;
                    w1_data   = {hit_val_reg, new_cnt};
                    w2_data   = {prev_val_reg, prev_cnt_reg};
                    after_idx = pred_idx;
                end
                else
                begin
                    w1_data = {hit_val_reg, new_cnt};
                end
            end
            default:
            begin
                w1_en = 1'b0;
            end
        endcase
    end

    // Single write port shared by the clearing pass, loads and reorder writes.
    assign slot_ext = {{IDX_W{1'b0}}, item_reg.slot};
    assign slot_ok  = int'(item_reg.slot) < TABLE_DEPTH;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg[IDX_W-1:0];
        wr_data = {sol_pkg::VALUE_W'(addr_reg), {COUNT_WIDTH{1'b0}}};
        if (cmd.clear_write)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.load_write)
        begin
            wr_en   = slot_ok;
            wr_addr = slot_ext[IDX_W-1:0];
            wr_data = {item_reg.load_value, {COUNT_WIDTH{1'b0}}};
        end
        else if (cmd.wr1)
        begin
            wr_en   = w1_en;
            wr_addr = w1_addr;
            wr_data = w1_data;
        end
        else if (cmd.wr2)
        begin
            wr_en   = w2_en;
            wr_addr = w2_addr;
            wr_data = w2_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rdata_reg <= mem_array[addr_reg[IDX_W-1:0]];
        end
    end

    assign status.is_load    = (item.command == sol_pkg::CMD_LOAD);
    assign status.clear_last = (addr_reg == CNT_W'(TABLE_DEPTH - 1));
    assign status.issued_all = (addr_reg == CNT_W'(TABLE_DEPTH));
    assign status.match      = match;
    assign status.last       = cmp_en && (ridx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign status.w2_en      = w2_en;

    assign result = result_reg;

endmodule

### src/sol_ctrl.sv
// Controller state machine of the self-organising list lookup.
module sol_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  sol_pkg::sol_status_t status,
    output sol_pkg::sol_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);

    sol_pkg::sol_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sol_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sol_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = sol_pkg::ST_IDLE;
                end
            end
            sol_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = status.is_load ? sol_pkg::ST_LOAD : sol_pkg::ST_SCAN;
                end
            end
            sol_pkg::ST_SCAN:
            begin
                if (status.match)
                begin
                    state_next = sol_pkg::ST_WR1;
                end
                else if (status.last)
                begin
                    state_next = sol_pkg::ST_DONE;
                end
            end
            sol_pkg::ST_WR1:
            begin
                state_next = status.w2_en ? sol_pkg::ST_WR2 : sol_pkg::ST_DONE;
            end
            sol_pkg::ST_WR2:  state_next = sol_pkg::ST_DONE;
            sol_pkg::ST_LOAD: state_next = sol_pkg::ST_DONE;
            sol_pkg::ST_DONE: state_next = sol_pkg::ST_IDLE;
            default:          state_next = sol_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            sol_pkg::ST_CLEAR:
            begin
                cmd.clear_write = 1'b1;
            end
            sol_pkg::ST_IDLE:
            begin
                busy           = 1'b0;
                cmd.latch_item = start;
            end
            sol_pkg::ST_SCAN:
            begin
                cmd.issue   = !status.issued_all;
                cmd.compare = 1'b1;
                cmd.res_en  = !status.match && status.last;
            end
            sol_pkg::ST_WR1:
            begin
                cmd.wr1     = 1'b1;
                cmd.res_en  = !status.w2_en;
                cmd.res_hit = 1'b1;
            end
            sol_pkg::ST_WR2:
            begin
                cmd.wr2     = 1'b1;
                cmd.res_en  = 1'b1;
                cmd.res_hit = 1'b1;
            end
            sol_pkg::ST_LOAD:
            begin
                cmd.load_write = 1'b1;
                cmd.res_en     = 1'b1;
            end
            sol_pkg::ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // An accepted item always makes the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    // The result strobe lasts exactly one cycle.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for more than one cycle");

    // A hit found during the scan is always followed by the first reorder write.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sol_pkg::ST_SCAN && status.match) |=> (state_reg == sol_pkg::ST_WR1))
        else $error("hit in scan not followed by reorder write");

    // Nothing is written to the table while the block is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !(cmd.wr1 || cmd.wr2 || cmd.load_write || cmd.clear_write))
        else $error("table write while idle");

    // A result is only reported when the block has been busy with an item.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

endmodule
